@@ sv/packed_tile_palette_blitter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed tile palette blitter
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_TILE_PALETTE_BLITTER_UNIT_ASSERT_SVH
`define PACKED_TILE_PALETTE_BLITTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTPB_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ptpb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptpb_pkg
// Constants, codes and controller/datapath interface types of the blitter.
// ----------------------------------------------------------------------------
package ptpb_pkg;

    localparam int TILE_SIDE       = 12;
    localparam int PIXELS_PER_TILE = 144;
    localparam int WORD_BITS       = 14;
    localparam int PALETTE_ENTRIES = 16;

    localparam int BYTE_W    = 8;
    localparam int BPP_W     = 3;
    localparam int IDX_W     = 4;
    localparam int PAL_SEL_W = 3;
    localparam int PAL_W     = BYTE_W << PAL_SEL_W;
    localparam int REM_W     = $clog2(WORD_BITS + 1);
    localparam int PC_W      = $clog2(PIXELS_PER_TILE + 1);
    localparam int PCX_W     = PC_W + 1;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAL_FIRST_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_FIRST_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_SECOND_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_SECOND_HIGH = 2'd3;

    localparam logic KIND_HEADER = 1'b0;

    // Display command codes
    localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

    // Window set-up sequence: eleven bytes, one per step
    localparam int CMD_BYTES = 11;
    localparam int STEP_W    = $clog2(CMD_BYTES);
    localparam logic [STEP_W-1:0] STEP_COL_CMD   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_COL_START = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_COL_END   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_ROW_CMD   = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_ROW_START = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_ROW_END   = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_WRITE_CMD = STEP_W'(CMD_BYTES - 1);

    typedef enum logic [1:0] {
        SEL_CMD,
        SEL_PIX0,
        SEL_PIX1
    } t_byte_sel;

    typedef struct packed {
        logic                load_hdr;
        logic                load_data;
        logic                take;
        logic                pix_end;
        logic                put;
        t_byte_sel           sel;
        logic [STEP_W-1:0]   step;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic held;
        logic take_emit;
        logic tile_end;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ sv/ptpb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "packed_tile_palette_blitter_unit_assert.svh"
// ----------------------------------------------------------------------------
// ptpb_ctrl
// Sequencer: window commands, pixel extraction and two-byte pixel output.
// ----------------------------------------------------------------------------
module ptpb_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_kind,
    input  wire ptpb_pkg::t_dp_status i_status,
    output ptpb_pkg::t_dp_cmd         o_cmd
);
    import ptpb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_TAKE,
        S_PIX0,
        S_PIX1
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd.load_hdr  = 1'b0;
        o_cmd.load_data = 1'b0;
        o_cmd.take      = 1'b0;
        o_cmd.pix_end   = 1'b0;
        o_cmd.put       = 1'b0;
        o_cmd.sel       = SEL_CMD;
        o_cmd.step      = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_HEADER) begin
                        o_cmd.load_hdr = 1'b1;
                        n_step         = '0;
                        n_state        = S_CMD;
                    end else if (i_status.active) begin
                        // send a held pixel before touching the new word
                        o_cmd.load_data = 1'b1;
                        n_state         = i_status.held ? S_PIX0 : S_TAKE;
                    end
                end
            end
            S_CMD: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    if (r_step == STEP_WRITE_CMD) begin
                        o_cmd.take = 1'b1;
                        n_state    = i_status.take_emit ? S_PIX0 : S_IDLE;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = i_status.take_emit ? S_PIX0 : S_IDLE;
            end
            S_PIX0: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    o_cmd.sel = SEL_PIX0;
                    n_state   = S_PIX1;
                end
            end
            S_PIX1: begin
                if (i_status.out_free) begin
                    o_cmd.put     = 1'b1;
                    o_cmd.sel     = SEL_PIX1;
                    o_cmd.pix_end = 1'b1;
                    if (i_status.tile_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = i_status.take_emit ? S_PIX0 : S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `PTPB_ASSERT_HOLDS(a_busy_tile_open, r_state != S_IDLE, i_status.active, "busy with no tile open")
    `PTPB_ASSERT_HOLDS(a_pix1_after_pix0, r_state == S_PIX1, $past(r_state) == S_PIX0 || $past(r_state) == S_PIX1, "second pixel byte without first")
    `PTPB_ASSERT_NEXT(a_tile_closes, o_cmd.pix_end && i_status.tile_end, !i_status.active, "tile left open after last pixel")

endmodule
`default_nettype wire

@@ sv/ptpb_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "packed_tile_palette_blitter_unit_assert.svh"
// ----------------------------------------------------------------------------
// ptpb_datapath
// Palette registers, bit buffer, index extraction and output register.
// ----------------------------------------------------------------------------
module ptpb_datapath (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [ptpb_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [ptpb_pkg::PAL_W-1:0]              i_cfg_data,
    input  wire logic [ptpb_pkg::BYTE_W-1:0]             i_col_start,
    input  wire logic [ptpb_pkg::BYTE_W-1:0]             i_row_start,
    input  wire logic [ptpb_pkg::WORD_BITS-1:0]          i_data_word,
    input  wire ptpb_pkg::t_dp_cmd                       i_cmd,
    output ptpb_pkg::t_dp_status                         o_status,
    input  wire logic                                    i_out_stall,
    output logic                                         o_out_valid,
    output logic [ptpb_pkg::BYTE_W-1:0]                  o_out_byte,
    output logic                                         o_is_command,
    output logic                                         o_last_of_run,
    output logic                                         o_tile_done
);
    import ptpb_pkg::*;

    logic [PAL_W-1:0]     r_pal_first_low, r_pal_first_high;
    logic [PAL_W-1:0]     r_pal_second_low, r_pal_second_high;
    logic [BYTE_W-1:0]    r_col, r_row;
    logic [WORD_BITS-1:0] r_buf;
    logic [REM_W-1:0]     r_rem;
    logic [PC_W-1:0]      r_pc;
    logic [IDX_W-1:0]     r_acc;
    logic [BPP_W-1:0]     r_taken, r_bpp;
    logic                 r_active;

    logic                 r_out_valid, r_out_cmd, r_out_last, r_out_done;
    logic [BYTE_W-1:0]    r_out_byte;

    logic [BPP_W-1:0]     base_taken, need, taken_next;
    logic [IDX_W-1:0]     base_acc, acc_next;
    logic [REM_W-1:0]     take_k, rem_next;
    logic [WORD_BITS-1:0] buf_next;
    logic [PCX_W-1:0]     pc_arg;
    logic                 complete, hold, take_emit, tile_end, out_free;
    logic [BYTE_W-1:0]    n_byte;
    logic                 n_cmd, n_last, n_done;

    function automatic logic [BYTE_W-1:0] pal_byte(input logic [PAL_W-1:0] lo,
                                                   input logic [PAL_W-1:0] hi,
                                                   input logic [IDX_W-1:0] idx);
        logic [PAL_W-1:0] row;
        begin
            row = idx[IDX_W-1] ? hi : lo;
            if (32'(idx) >= PALETTE_ENTRIES) begin
                return '0;
            end
            return row[BYTE_W*idx[PAL_SEL_W-1:0] +: BYTE_W];
        end
    endfunction

    // Pixel extraction: take up to one index worth of bits, first bit to MSB
    always_comb begin
        base_taken = i_cmd.pix_end ? '0 : r_taken;
        base_acc   = i_cmd.pix_end ? '0 : r_acc;
        need       = r_bpp - base_taken;
        take_k     = (REM_W'(need) <= r_rem) ? REM_W'(need) : r_rem;
        acc_next   = base_acc;
        for (int i = 0; i < IDX_W; i++) begin
            if (REM_W'(i) < take_k) begin
                acc_next = {acc_next[IDX_W-2:0], r_buf[i]};
            end
        end
        buf_next   = r_buf >> take_k;
        rem_next   = r_rem - take_k;
        taken_next = base_taken + BPP_W'(take_k);
        pc_arg     = i_cmd.pix_end ? ({1'b0, r_pc} + PCX_W'(1)) : {1'b0, r_pc};
        complete   = (taken_next == r_bpp);
        // hold back an index finished by the word's last bit unless it ends the tile
        hold       = complete && (rem_next == '0) &&
                     ((pc_arg + PCX_W'(1)) < PCX_W'(PIXELS_PER_TILE));
        take_emit  = complete && !hold;
        tile_end   = (({1'b0, r_pc} + PCX_W'(1)) >= PCX_W'(PIXELS_PER_TILE));
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.active    = r_active;
    assign o_status.held      = (r_taken == r_bpp);
    assign o_status.take_emit = take_emit;
    assign o_status.tile_end  = tile_end;
    assign o_status.out_free  = out_free;

    always_comb begin
        n_byte = '0;
        n_cmd  = 1'b0;
        n_last = 1'b0;
        n_done = 1'b0;
        unique case (i_cmd.sel)
            SEL_CMD: begin
                unique case (i_cmd.step)
                    STEP_COL_CMD: begin
                        n_byte = CMD_COLUMN;
                        n_cmd  = 1'b1;
                    end
                    STEP_COL_START: n_byte = r_col;
                    STEP_COL_END:   n_byte = r_col + BYTE_W'(TILE_SIDE - 1);
                    STEP_ROW_CMD: begin
                        n_byte = CMD_ROW;
                        n_cmd  = 1'b1;
                    end
                    STEP_ROW_START: n_byte = r_row;
                    STEP_ROW_END:   n_byte = r_row + BYTE_W'(TILE_SIDE - 1);
                    STEP_WRITE_CMD: begin
                        n_byte = CMD_WRITE;
                        n_cmd  = 1'b1;
                        n_last = !take_emit;
                    end
                    default: n_byte = '0;
                endcase
            end
            SEL_PIX0: begin
                n_byte = pal_byte(r_pal_first_low, r_pal_first_high, r_acc);
            end
            SEL_PIX1: begin
                n_byte = pal_byte(r_pal_second_low, r_pal_second_high, r_acc);
                n_done = tile_end;
                n_last = tile_end || !take_emit;
            end
            default: n_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_first_low   <= '0;
            r_pal_first_high  <= '0;
            r_pal_second_low  <= '0;
            r_pal_second_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAL_FIRST_LOW:   r_pal_first_low   <= i_cfg_data;
                REG_PAL_FIRST_HIGH:  r_pal_first_high  <= i_cfg_data;
                REG_PAL_SECOND_LOW:  r_pal_second_low  <= i_cfg_data;
                REG_PAL_SECOND_HIGH: r_pal_second_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hdr) begin
            r_col <= i_col_start;
            r_row <= i_row_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_rem    <= '0;
            r_pc     <= '0;
            r_acc    <= '0;
            r_taken  <= '0;
            r_bpp    <= BPP_W'(1);
            r_active <= 1'b0;
        end else begin
            priority if (i_cmd.load_hdr) begin
                r_bpp    <= BPP_W'(i_data_word[1:0]) + BPP_W'(1);
                r_buf    <= {2'b00, i_data_word[WORD_BITS-1:2]};
                r_rem    <= REM_W'(WORD_BITS - 2);
                r_pc     <= '0;
                r_acc    <= '0;
                r_taken  <= '0;
                r_active <= 1'b1;
            end else if (i_cmd.load_data) begin
                r_buf <= i_data_word;
                r_rem <= REM_W'(WORD_BITS);
            end else if (i_cmd.pix_end && tile_end) begin
                // close the tile and drop leftover bits
                r_active <= 1'b0;
                r_buf    <= '0;
                r_rem    <= '0;
                r_pc     <= '0;
                r_acc    <= '0;
                r_taken  <= '0;
            end else if (i_cmd.pix_end || i_cmd.take) begin
                if (i_cmd.pix_end) begin
                    r_pc <= r_pc + PC_W'(1);
                end
                r_acc   <= acc_next;
                r_taken <= taken_next;
                r_buf   <= buf_next;
                r_rem   <= rem_next;
            end else begin
                r_active <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_byte <= n_byte;
            r_out_cmd  <= n_cmd;
            r_out_last <= n_last;
            r_out_done <= n_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_command  = r_out_cmd;
    assign o_last_of_run = r_out_last;
    assign o_tile_done   = r_out_done;

    `PTPB_ASSERT_HOLDS(a_put_needs_room, i_cmd.put, out_free, "output register overwritten")
    `PTPB_ASSERT_HOLDS(a_taken_bounded, 1'b1, r_taken <= r_bpp, "index bits exceed pixel depth")
    `PTPB_ASSERT_HOLDS(a_done_is_last, r_out_valid && r_out_done, r_out_last, "tile end not last byte")

endmodule
`default_nettype wire

@@ sv/packed_tile_palette_blitter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_tile_palette_blitter_unit
// Palette-indexed 12x12 tile blitter emitting a display command/data stream.
// ----------------------------------------------------------------------------
// A header transaction (kind 0) opens a tile: it produces the column window
// command 0x2A with bytes 0, x, 0, x+11, the row window command 0x2B with
// bytes 0, y, 0, y+11 (end coordinates wrap at 8 bits) and the memory write
// command 0x2C, followed by the pixels found in its upper 12 bits. Its low
// two bits set 1 to 4 bits per pixel. Each data transaction (kind 1) adds 14
// bits, least significant first, the first bit of an index being its most
// significant. Every pixel produces two data bytes from the palette, first
// colour byte then second. A pixel completed by the last bit of a word is
// sent at the start of the next data transaction, unless it is the tile's
// last; data transactions with no open tile produce nothing. Timing: the
// block takes one transaction at a time and sends one byte per cycle
// through a single output register while the output does not stall. A
// header is taken, then its commands and pixels are sent; a data
// transaction is taken, then, unless a held pixel leads it, its bits are
// extracted before its pixels are sent. The next transaction is taken in
// the cycle after the last byte is produced, while that byte may still
// wait in the output register. Palette registers reset to zero and are
// written with o_cfg_ready always high.
// ----------------------------------------------------------------------------
module packed_tile_palette_blitter_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input item channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_kind,
    input  wire logic [ptpb_pkg::BYTE_W-1:0]      i_col_start,
    input  wire logic [ptpb_pkg::BYTE_W-1:0]      i_row_start,
    input  wire logic [ptpb_pkg::WORD_BITS-1:0]   i_data_word,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [ptpb_pkg::BYTE_W-1:0]           o_out_byte,
    output logic                                  o_is_command,
    output logic                                  o_last_of_run,
    output logic                                  o_tile_done,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ptpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ptpb_pkg::PAL_W-1:0]       i_cfg_data
);
    import ptpb_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Configuration is to be written only while idle, a rule left to the user: accept every write at once
    assign o_cfg_ready = 1'b1;

    // Sequence window commands and pixels, one byte per cycle unless stalled
    ptpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Hold palette, bit buffer and index state; drive the output register
    ptpb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_col_start   (i_col_start),
        .i_row_start   (i_row_start),
        .i_data_word   (i_data_word),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_is_command  (o_is_command),
        .o_last_of_run (o_last_of_run),
        .o_tile_done   (o_tile_done)
    );

endmodule
`default_nettype wire

@@ sim/tb_packed_tile_palette_blitter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_tile_palette_blitter_unit
// Self-checking bench for the palette-indexed tile blitter.
// ----------------------------------------------------------------------------
// Tiles go in as a header transaction followed by packed data transactions.
// A cycle-free model of the blitter runs on every accepted transaction and
// queues the display bytes it should cause: window commands, then two
// palette bytes per pixel. Every byte leaving the block is checked field by
// field against the oldest queued byte. Palettes are rewritten between
// phases while the block is quiet; both channels idle at random, one phase
// runs with no idling at all and the output holds off once for a long spell.
// ----------------------------------------------------------------------------
module tb_packed_tile_palette_blitter_unit;
    import ptpb_pkg::*;

    localparam int  HALF_PERIOD  = 4;
    localparam int  RUN_LIMIT    = 400000;
    localparam int  SETTLE       = 40;    // covers transactions that cause no bytes
    localparam int  PHASE_ITEMS  = 95;
    localparam int  IDLE_PERCENT = 16;
    localparam int  HOLD_AFTER   = 1200;  // bytes seen before the long hold-off
    localparam int  HOLD_CYCLES  = 500;
    localparam logic KIND_DATA   = !KIND_HEADER;

    // One transaction on the input channel
    typedef struct packed {
        logic                 kind;
        logic [BYTE_W-1:0]    col;
        logic [BYTE_W-1:0]    row;
        logic [WORD_BITS-1:0] word;
    } tile_word_t;

    // One byte on the display stream, with its flags
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              cmd;
        logic              last;
        logic              done;
    } disp_byte_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_kind      = KIND_HEADER;
    logic [BYTE_W-1:0]    i_col_start = '0;
    logic [BYTE_W-1:0]    i_row_start = '0;
    logic [WORD_BITS-1:0] i_data_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_is_command;
    logic                 o_last_of_run;
    logic                 o_tile_done;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_PAL_FIRST_LOW;
    logic [PAL_W-1:0]     i_cfg_data  = '0;

    packed_tile_palette_blitter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_col_start   (i_col_start),
        .i_row_start   (i_row_start),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_is_command  (o_is_command),
        .o_last_of_run (o_last_of_run),
        .o_tile_done   (o_tile_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    tile_word_t word_q[$];         // transactions waiting to be offered
    tile_word_t offered;           // transaction currently on the input port
    bit         offer_taken = 1'b0;
    bit         quiet       = 1'b0; // no random idling on either side
    bit         hold_used   = 1'b0;
    int         hold_left   = 0;
    int         bytes_seen  = 0;
    int         errors      = 0;
    int         cycles      = 0;

    // ------------------------------------------------------------------------
    // Blitter model: palette copy, unpacking state and the byte stream owed
    // ------------------------------------------------------------------------
    logic [PAL_W-1:0]     pal_reg [4] = '{default: '0};
    logic [WORD_BITS-1:0] shift_buf  = '0;
    int unsigned          shift_left = 0;
    int unsigned          pix_cnt    = 0;
    logic [IDX_W-1:0]     pal_idx    = '0;
    int unsigned          idx_bits   = 0;
    int unsigned          bpp        = 1;
    bit                   tile_open  = 1'b0;
    disp_byte_t           run_q[$];          // bytes of the transaction in hand
    disp_byte_t           byte_stream_q[$];  // bytes owed by the block, oldest first

    function automatic void put_byte(input logic [BYTE_W-1:0] b, input logic c,
                                     input logic d);
        disp_byte_t nb;
        nb.data = b;
        nb.cmd  = c;
        nb.last = 1'b0;
        nb.done = d;
        run_q.push_back(nb);
    endfunction

    function automatic logic [BYTE_W-1:0] pal_lookup(input logic [PAL_W-1:0] lo,
                                                     input logic [PAL_W-1:0] hi,
                                                     input logic [IDX_W-1:0] idx);
        logic [PAL_W-1:0] sel;
        sel = idx[3] ? hi : lo;
        return sel[idx[2:0]*8 +: 8];
    endfunction

    // Send both colour bytes of the index in hand; close the tile on its
    // last pixel and drop whatever bits are left
    function automatic void send_pixel();
        logic [BYTE_W-1:0] first_b;
        logic [BYTE_W-1:0] second_b;
        bit                fin;
        first_b  = pal_lookup(pal_reg[REG_PAL_FIRST_LOW], pal_reg[REG_PAL_FIRST_HIGH],
                              pal_idx);
        second_b = pal_lookup(pal_reg[REG_PAL_SECOND_LOW], pal_reg[REG_PAL_SECOND_HIGH],
                              pal_idx);
        pix_cnt++;
        fin = (pix_cnt >= PIXELS_PER_TILE);
        put_byte(first_b, 1'b0, 1'b0);
        put_byte(second_b, 1'b0, fin);
        pal_idx  = '0;
        idx_bits = 0;
        if (fin) begin
            tile_open  = 1'b0;
            shift_buf  = '0;
            shift_left = 0;
            pix_cnt    = 0;
        end
    endfunction

    // Shift bits into the index, LSB of the word first, MSB of the index
    // first. An index finished by the word's last bit waits for the next
    // data word, unless it closes the tile.
    function automatic void unpack_bits();
        bit held;
        held = 1'b0;
        while (tile_open && shift_left > 0 && !held) begin
            pal_idx   = {pal_idx[IDX_W-2:0], shift_buf[0]};
            shift_buf = shift_buf >> 1;
            shift_left--;
            idx_bits++;
            if (idx_bits >= bpp) begin
                if (shift_left == 0 && pix_cnt + 1 < PIXELS_PER_TILE)
                    held = 1'b1;
                else
                    send_pixel();
            end
        end
    endfunction

    function automatic void blit_item(input tile_word_t it);
        logic [BYTE_W-1:0] col_end;
        logic [BYTE_W-1:0] row_end;
        disp_byte_t        tail;
        run_q.delete();
        if (it.kind == KIND_HEADER) begin
            // Window set-up; end coordinates wrap at 8 bits
            col_end = it.col + BYTE_W'(TILE_SIDE - 1);
            row_end = it.row + BYTE_W'(TILE_SIDE - 1);
            put_byte(CMD_COLUMN, 1'b1, 1'b0);
            put_byte(8'h00, 1'b0, 1'b0);
            put_byte(it.col, 1'b0, 1'b0);
            put_byte(8'h00, 1'b0, 1'b0);
            put_byte(col_end, 1'b0, 1'b0);
            put_byte(CMD_ROW, 1'b1, 1'b0);
            put_byte(8'h00, 1'b0, 1'b0);
            put_byte(it.row, 1'b0, 1'b0);
            put_byte(8'h00, 1'b0, 1'b0);
            put_byte(row_end, 1'b0, 1'b0);
            put_byte(CMD_WRITE, 1'b1, 1'b0);
            bpp        = it.word[1:0] + 1;
            shift_buf  = it.word >> 2;
            shift_left = WORD_BITS - 2;
            pix_cnt    = 0;
            pal_idx    = '0;
            idx_bits   = 0;
            tile_open  = 1'b1;
            unpack_bits();
        end else if (tile_open) begin
            // Flush a held pixel first, then take the new bits
            if (idx_bits >= bpp)
                send_pixel();
            if (tile_open) begin
                shift_buf  = it.word;
                shift_left = WORD_BITS;
                unpack_bits();
            end
        end
        if (run_q.size() != 0) begin
            tail      = run_q.pop_back();
            tail.last = 1'b1;
            run_q.push_back(tail);
        end
        foreach (run_q[k])
            byte_stream_q.push_back(run_q[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: advance on the falling edge, hold the payload while stalled
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        tile_word_t nxt;
        if (i_rst_n && (!i_in_valid || offer_taken)) begin
            offer_taken = 1'b0;
            if (word_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                nxt          = word_q.pop_front();
                offered      = nxt;
                i_in_valid  <= 1'b1;
                i_kind      <= nxt.kind;
                i_col_start <= nxt.col;
                i_row_start <= nxt.row;
                i_data_word <= nxt.word;
            end else begin
                i_in_valid  <= 1'b0;
            end
        end
    end

    // Run the model on each transaction the block takes
    always @(posedge i_clk) begin : take_in
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            blit_item(offered);
            offer_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, one long hold-off so the block backs up
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_stall
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_used && bytes_seen >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic check_field(input string what, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Compare every accepted byte with the oldest one owed
    always @(posedge i_clk) begin : watch_out
        disp_byte_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            bytes_seen++;
            if (byte_stream_q.size() == 0) begin
                $display("%0t: unexpected byte expected none actual %0h cmd %0b last %0b done %0b",
                         $time, o_out_byte, o_is_command, o_last_of_run, o_tile_done);
                errors++;
            end else begin
                want = byte_stream_q.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("is_command", want.cmd, o_is_command);
                check_field("last_of_run", want.last, o_last_of_run);
                check_field("tile_done", want.done, o_tile_done);
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("packed_tile_palette_blitter_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic k, input logic [BYTE_W-1:0] c,
                              input logic [BYTE_W-1:0] r, input logic [WORD_BITS-1:0] w);
        tile_word_t it;
        it.kind = k;
        it.col  = c;
        it.row  = r;
        it.word = w;
        word_q.push_back(it);
    endtask

    // Data words a tile needs after its header to reach its last pixel
    function automatic int words_for(input int bsel);
        return (PIXELS_PER_TILE * bsel - (WORD_BITS - 2) + WORD_BITS - 1) / WORD_BITS;
    endfunction

    function automatic logic [WORD_BITS-1:0] pixel_bits();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return WORD_BITS'($urandom_range(16383));
    endfunction

    // Header with random window and first bits, then n data words
    task automatic queue_tile(input int bsel, input int n);
        logic [WORD_BITS-3:0] first_bits;
        first_bits = (WORD_BITS-2)'(pixel_bits() >> 2);
        queue_word(KIND_HEADER, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                   {first_bits, 2'(bsel - 1)});
        repeat (n)
            queue_word(KIND_DATA, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                       pixel_bits());
    endtask

    task automatic write_palette(input logic [CFG_IDX_W-1:0] idx, input logic [PAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pal_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_palettes(input logic [PAL_W-1:0] f_lo, input logic [PAL_W-1:0] f_hi,
                                 input logic [PAL_W-1:0] s_lo, input logic [PAL_W-1:0] s_hi);
        write_palette(REG_PAL_FIRST_LOW, f_lo);
        write_palette(REG_PAL_FIRST_HIGH, f_hi);
        write_palette(REG_PAL_SECOND_LOW, s_lo);
        write_palette(REG_PAL_SECOND_HIGH, s_hi);
    endtask

    function automatic logic [PAL_W-1:0] rand_pal();
        return {$urandom(), $urandom()};
    endfunction

    // Hold off the sender until the queue is drained and every owed byte
    // has come out, then let the block settle
    task automatic wait_quiet();
        while (word_q.size() != 0 || i_in_valid || byte_stream_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_count;
        int pick;
        int bsel;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_palettes(rand_pal(), rand_pal(), rand_pal(), rand_pal());

        // Directed: stray word before any tile, abandoned tiles at 4 bpp (at the far
        // corner with wrapping window ends), 2 and 3 bpp, then a whole 1 bpp tile
        // whose held pixels, discarded tail bits and trailing stray word are all
        // exercised
        queue_word(KIND_DATA, 8'hFF, 8'hFF, '1);
        queue_word(KIND_HEADER, 8'hFF, 8'hFF, {12'hFFF, 2'd3});
        queue_word(KIND_DATA, 8'h00, 8'h00, '0);
        queue_word(KIND_HEADER, 8'h00, 8'h00, {12'hFFF, 2'd1});
        queue_word(KIND_DATA, 8'h55, 8'hAA, 14'h2AAA);
        queue_word(KIND_HEADER, 8'hF4, 8'hFA, {12'h5A5, 2'd2});
        queue_word(KIND_DATA, 8'hAA, 8'h55, 14'h1555);
        queue_word(KIND_HEADER, 8'h80, 8'h7F, {12'hFFF, 2'd0});
        for (int w = 0; w < words_for(1); w++) begin
            if (w == 0)
                queue_word(KIND_DATA, 8'h00, 8'hFF, '1);
            else if (w == 1)
                queue_word(KIND_DATA, 8'hFF, 8'h00, '0);
            else
                queue_word(KIND_DATA, 8'h00, 8'h00, pixel_bits());
        end
        queue_word(KIND_DATA, 8'h00, 8'h00, 14'h3C3C);
        wait_quiet();

        // Random phases, each with its own palette; phase 2 runs flat out
        for (int p = 1; p <= 4; p++) begin
            quiet = (p == 2);
            case (p)
                1: begin
                    load_palettes('1, '1, '1, '1);
                end
                3: begin
                    load_palettes('0, '0, '0, '0);
                end
                default: begin
                    load_palettes(rand_pal(), rand_pal(), rand_pal(), rand_pal());
                end
            endcase
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                bsel = $urandom_range(1, 4);
                if (pick < 78) begin
                    queue_tile(bsel, words_for(bsel));
                    phase_count += 1 + words_for(bsel);
                end else if (pick < 92) begin
                    // abandoned by whatever header comes next
                    n = $urandom_range(words_for(bsel) - 1);
                    queue_tile(bsel, n);
                    phase_count += 1 + n;
                end else begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        queue_word(KIND_DATA, BYTE_W'($urandom_range(255)),
                                   BYTE_W'($urandom_range(255)), pixel_bits());
                    phase_count += n;
                end
            end
            wait_quiet();
        end

        if (errors == 0)
            $display("packed_tile_palette_blitter_unit regression: pass");
        else
            $display("packed_tile_palette_blitter_unit regression: fail");
        $finish;
    end

endmodule
